// ===== design/slt_pkg.sv =====
// Shared types, character codes and token kinds for the shell line tokenizer.
// No dependencies; used by every module in the design folder.
package slt_pkg;

    // Longest word that is stored; later word characters are dropped
    localparam int MAX_WORD_LEN = 511;
    localparam logic [8:0] LEN_SAT = 9'd511;

    // Lexer mode codes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_WORD = 2'd1;
    localparam logic [1:0] MODE_TAG  = 2'd2;

    // Held operator codes
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_AMP  = 2'd1;
    localparam logic [1:0] OP_BAR  = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_CHAR = 3'd0;
    localparam logic [2:0] KIND_WEND = 3'd1;
    localparam logic [2:0] KIND_AND  = 3'd2;
    localparam logic [2:0] KIND_OR   = 3'd3;
    localparam logic [2:0] KIND_PIPE = 3'd4;
    localparam logic [2:0] KIND_BG   = 3'd5;
    localparam logic [2:0] KIND_LEND = 3'd6;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_char;
        logic [8:0] word_length;
        logic [7:0] token_number;
        logic       last;
    } result_t;

    // Results caused by one input transaction (zero to two)
    typedef struct packed {
        logic [1:0] count;
        result_t    res1;
        result_t    res0;
    } lex_out_t;

    function automatic result_t make_result(input logic [2:0] kind, input logic [7:0] chr,
                                            input logic [8:0] len, input logic [7:0] num);
        result_t r;
        r.kind         = kind;
        r.out_char     = chr;
        r.word_length  = len;
        r.token_number = num;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

// ===== design/shell_line_tokenizer_core.sv =====
// Shell line tokenizer, top level: one line character per transaction in,
// a stream of word characters, word ends, operator tokens and line ends out.
// Results are registered in the result buffer before they are offered.
// Throughput: one input per cycle while the result buffer has a free slot; an input causing
// two results holds the output port for both, as the two-slot result buffer drains one result a cycle.
// Reset (rst_n low, asynchronous): lexer idle, counters zero, buffer empty.
module shell_line_tokenizer_core (
    input  logic       clk,
    input  logic       rst_n,
    // Input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic [7:0] ch,
    // Output channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] kind,
    output logic [7:0] out_char,
    output logic [8:0] word_length,
    output logic [7:0] token_number,
    output logic       last
);

    slt_pkg::lex_out_t lex_out;
    slt_pkg::result_t  head;
    logic              accept;
    logic              can_push;

    // Take a transaction whenever the buffer has a free slot; a result still
    // waiting in the head slot does not stall the input side.
    assign in_ready = can_push;
    assign accept   = in_valid && in_ready;

    // The lexer evaluates the current character against its state in one pass
    // and advances its state on every accepted transaction.
    slt_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .action  (action),
        .ch      (ch),
        .lex_out (lex_out)
    );

    // Drop transactions that produce nothing (blanks between tokens, held
    // operators, quotes, dropped long-word characters).
    slt_out_buffer u_out_buffer (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept && (lex_out.count != 2'd0)),
        .push_data  (lex_out),
        .can_push   (can_push),
        .head_valid (out_valid),
        .head_ready (out_ready),
        .head       (head)
    );

    assign kind         = head.kind;
    assign out_char     = head.out_char;
    assign word_length  = head.word_length;
    assign token_number = head.token_number;
    assign last         = head.last;

endmodule

// ===== design/slt_lexer.sv =====
// Lexer state registers and the single-pass next-state / result logic.
// Depends on slt_pkg.
module slt_lexer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              action,
    input  logic [7:0]        ch,
    output slt_pkg::lex_out_t lex_out
);

    logic [1:0] mode_reg,  mode_next;
    logic       quote_reg, quote_next;
    logic       angle_reg, angle_next;
    logic [1:0] op_reg,    op_next;
    logic [9:0] wc_reg,    wc_next;
    logic [7:0] tc_reg,    tc_next;

    always_comb
    begin
        slt_pkg::result_t res [2];
        logic [1:0] n;
        logic       is_space;
        logic       is_op;
        logic       do_handle;
        logic       do_word;
        logic       do_store;
        logic [8:0] len;

        mode_next  = mode_reg;
        quote_next = quote_reg;
        angle_next = angle_reg;
        op_next    = op_reg;
        wc_next    = wc_reg;
        tc_next    = tc_reg;
        res[0]     = '0;
        res[1]     = '0;
        n          = 2'd0;
        do_handle  = 1'b0;
        do_word    = 1'b0;
        do_store   = 1'b0;
        is_space   = (ch == slt_pkg::CH_SPACE) || (ch == slt_pkg::CH_TAB);
        is_op      = (ch == slt_pkg::CH_AMP) || (ch == slt_pkg::CH_BAR);
        len        = (wc_reg > 10'(slt_pkg::LEN_SAT)) ? slt_pkg::LEN_SAT : wc_reg[8:0];

        if (action || ch == slt_pkg::CH_NUL)
        begin
            // End of line: flush held operator, close open word, then line end
            if (op_reg != slt_pkg::OP_NONE)
            begin
                res[n[0]] = slt_pkg::make_result(
                    (op_reg == slt_pkg::OP_AMP) ? slt_pkg::KIND_BG : slt_pkg::KIND_PIPE,
                    8'd0, 9'd0, tc_next);
                n = n + 2'd1;
                if (tc_next != 8'hFF) tc_next = tc_next + 8'd1;
            end
            if (mode_reg == slt_pkg::MODE_WORD || mode_reg == slt_pkg::MODE_TAG)
            begin
                res[n[0]] = slt_pkg::make_result(slt_pkg::KIND_WEND, 8'd0, len, tc_next);
                n = n + 2'd1;
                if (tc_next != 8'hFF) tc_next = tc_next + 8'd1;
            end
            if (!n[1])
            begin
                res[n[0]] = slt_pkg::make_result(slt_pkg::KIND_LEND, 8'd0, 9'd0, tc_next);
                n = n + 2'd1;
            end
            mode_next  = slt_pkg::MODE_IDLE;
            quote_next = 1'b0;
            angle_next = 1'b0;
            op_next    = slt_pkg::OP_NONE;
            wc_next    = 10'd0;
            tc_next    = 8'd0;
        end
        else
        begin
            do_handle = 1'b1;
            if (op_reg != slt_pkg::OP_NONE)
            begin
                if (op_reg == slt_pkg::OP_AMP && ch == slt_pkg::CH_AMP)
                begin
                    res[n[0]] = slt_pkg::make_result(slt_pkg::KIND_AND, 8'd0, 9'd0, tc_next);
                    do_handle = 1'b0;
                end
                else if (op_reg == slt_pkg::OP_BAR && ch == slt_pkg::CH_BAR)
                begin
                    res[n[0]] = slt_pkg::make_result(slt_pkg::KIND_OR, 8'd0, 9'd0, tc_next);
                    do_handle = 1'b0;
                end
                else
                begin
                    res[n[0]] = slt_pkg::make_result(
                        (op_reg == slt_pkg::OP_AMP) ? slt_pkg::KIND_BG : slt_pkg::KIND_PIPE,
                        8'd0, 9'd0, tc_next);
                end
                n = n + 2'd1;
                if (tc_next != 8'hFF) tc_next = tc_next + 8'd1;
                op_next = slt_pkg::OP_NONE;
            end

            if (do_handle)
            begin
                if (mode_reg == slt_pkg::MODE_TAG)
                begin
                    do_store = 1'b1;
                    if (ch == slt_pkg::CH_GT) mode_next = slt_pkg::MODE_WORD;
                end
                else if (mode_reg == slt_pkg::MODE_WORD)
                    do_word = 1'b1;
                else if (is_space)
                    do_word = 1'b0;
                else if (is_op)
                    op_next = (ch == slt_pkg::CH_AMP) ? slt_pkg::OP_AMP : slt_pkg::OP_BAR;
                else
                begin
                    mode_next = slt_pkg::MODE_WORD;
                    do_word   = 1'b1;
                end
            end

            if (do_word)
            begin
                if (!quote_reg && (is_space || is_op))
                begin
                    // Word ends here
                    res[n[0]] = slt_pkg::make_result(slt_pkg::KIND_WEND, 8'd0, len, tc_next);
                    n = n + 2'd1;
                    if (tc_next != 8'hFF) tc_next = tc_next + 8'd1;
                    wc_next    = 10'd0;
                    quote_next = 1'b0;
                    angle_next = 1'b0;
                    mode_next  = slt_pkg::MODE_IDLE;
                    if (is_op)
                        op_next = (ch == slt_pkg::CH_AMP) ? slt_pkg::OP_AMP : slt_pkg::OP_BAR;
                end
                else if (ch == slt_pkg::CH_QUOTE)
                begin
                    quote_next = ~quote_reg;
                    angle_next = 1'b0;
                end
                else if (angle_reg && ch == slt_pkg::CH_OPEN)
                begin
                    angle_next = 1'b0;
                    mode_next  = slt_pkg::MODE_TAG;
                    do_store   = 1'b1;
                end
                else
                begin
                    angle_next = !quote_reg && (ch == slt_pkg::CH_LT);
                    do_store   = 1'b1;
                end
            end

            // Store a word character unless the word is full
            if (do_store && wc_reg < 10'(slt_pkg::MAX_WORD_LEN) && !n[1])
            begin
                res[n[0]] = slt_pkg::make_result(slt_pkg::KIND_CHAR, ch, 9'd0, tc_next);
                n = n + 2'd1;
                wc_next = wc_reg + 10'd1;
            end
        end

        if (n == 2'd1) res[0].last = 1'b1;
        if (n == 2'd2) res[1].last = 1'b1;

        lex_out.count = n;
        lex_out.res0  = res[0];
        lex_out.res1  = res[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= slt_pkg::MODE_IDLE;
            quote_reg <= 1'b0;
            angle_reg <= 1'b0;
            op_reg    <= slt_pkg::OP_NONE;
            wc_reg    <= 10'd0;
            tc_reg    <= 8'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            angle_reg <= angle_next;
            op_reg    <= op_next;
            wc_reg    <= wc_next;
            tc_reg    <= tc_next;
        end
    end

endmodule

// ===== design/slt_out_buffer.sv =====
// Two-slot result buffer: each slot holds the results of one input transaction.
// Depends on slt_pkg.
module slt_out_buffer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  slt_pkg::lex_out_t push_data,
    output logic              can_push,
    output logic              head_valid,
    input  logic              head_ready,
    output slt_pkg::result_t  head
);

    logic              slot0_valid_reg;
    logic              slot1_valid_reg;
    slt_pkg::lex_out_t slot0_reg;
    slt_pkg::lex_out_t slot1_reg;
    logic              idx_reg;
    logic              pop;

    assign can_push   = !slot1_valid_reg;
    assign head_valid = slot0_valid_reg;
    assign head       = idx_reg ? slot0_reg.res1 : slot0_reg.res0;
    assign pop        = slot0_valid_reg && head_ready && head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot0_valid_reg <= 1'b0;
            slot1_valid_reg <= 1'b0;
            idx_reg         <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                idx_reg <= 1'b0;
                if (slot1_valid_reg)
                begin
                    slot0_valid_reg <= 1'b1;
                    slot1_valid_reg <= 1'b0;
                end
                else
                    slot0_valid_reg <= push;
            end
            else
            begin
                if (slot0_valid_reg && head_ready) idx_reg <= 1'b1;
                if (push)
                begin
                    if (slot0_valid_reg) slot1_valid_reg <= 1'b1;
                    else                 slot0_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Payload moves without reset
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (slot1_valid_reg) slot0_reg <= slot1_reg;
            else if (push)       slot0_reg <= push_data;
        end
        else if (push)
        begin
            if (slot0_valid_reg) slot1_reg <= push_data;
            else                 slot0_reg <= push_data;
        end
    end

endmodule
